// ----- hw/rtl/btld_pkg.sv -----
// Package for the balanced base-27 length decoder.
// Holds field widths, status codes and the decoder state and result types.
// No dependencies.
`default_nettype none

package btld_pkg;

    // Field and state widths.
    localparam int TRYTE_W  = 5;
    localparam int VALUE_W  = 61;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;
    localparam int SUM_W    = 62;
    localparam int WEIGHT_W = 58;

    // Beat widths on the stream ports.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 64;

    // Largest magnitude a digit tryte may carry.
    localparam logic signed [TRYTE_W-1:0] TRYTE_MAX = 5'sd13;
    localparam logic signed [TRYTE_W-1:0] TRYTE_MIN = -5'sd13;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EOD       = 3'd1,
        ST_BAD_COUNT = 3'd2,
        ST_BAD_TOP   = 3'd3,
        ST_TOO_LARGE = 3'd4
    } btld_status_t;

    // Decoder state carried from one tryte to the next.
    typedef struct packed {
        logic                awaiting_count;
        logic [COUNT_W-1:0]  digits_left;
        logic [SUM_W-1:0]    partial_sum;    // two's complement
        logic [WEIGHT_W-1:0] digit_weight;
    } btld_state_t;

    // Outcome of one decode step.
    typedef struct packed {
        logic               emit;
        logic [VALUE_W-1:0] value;
        btld_status_t       status;
    } btld_result_t;

    // State after reset or after a finished value.
    localparam btld_state_t STATE_IDLE = '{
        awaiting_count: 1'b1,
        digits_left:    '0,
        partial_sum:    '0,
        digit_weight:   WEIGHT_W'(1)
    };

endpackage

`default_nettype wire

// ----- hw/rtl/balanced_tryte_length_decoder.sv -----
// Top level of the balanced base-27 length decoder.
// Input register, one decode step and a result register; uses btld_pkg and btld_step.
//
// The block takes one tryte per beat and accepts a new beat in every clock cycle
// while no result is stalled. A beat with the end flag set ends the stream. The
// first tryte of a run is the digit count, the following ones are the digits, least
// significant first. One result beat leaves for each finished value, for each error
// and for each end beat; other trytes give none. An accepted tryte sits in the input
// register and passes to the result register when that register can take a beat; the
// multiply-add between the two registers is the longest path. A stalled result holds
// the result register and the input register, after which s_tready drops.
`default_nettype none

module balanced_tryte_length_decoder #(
    parameter int MAX_DIGITS = 13,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Tryte stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [btld_pkg::S_TDATA_W-1:0]     s_tdata,  // [4:0] tryte_value
    input  wire logic                               s_tuser,  // [0] stream_ended
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [btld_pkg::M_TDATA_W-1:0]          m_tdata   // [60:0] decoded_value,
                                                              // [63:61] status
);

    logic                                   in_valid_reg;
    logic signed [btld_pkg::TRYTE_W-1:0]    in_tryte_reg;
    logic                                   in_ended_reg;
    btld_pkg::btld_state_t                  state_reg;
    btld_pkg::btld_state_t                  state_next;
    btld_pkg::btld_result_t                 step_result;
    logic                                   out_valid_reg;
    logic [btld_pkg::VALUE_W-1:0]           out_value_reg;
    btld_pkg::btld_status_t                 out_status_reg;
    logic                                   out_free;
    logic                                   advance;

    // Handshake: the step fires when the result register can take a beat.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_tryte_reg <= $signed(s_tdata[btld_pkg::TRYTE_W-1:0]);
            in_ended_reg <= s_tuser;
        end
    end

    // Decode step.
    btld_step #(
        .MAX_DIGITS (MAX_DIGITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .state      (state_reg),
        .tryte      (in_tryte_reg),
        .ended      (in_ended_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= btld_pkg::STATE_IDLE;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_result.emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_result.emit) begin
            out_value_reg  <= step_result.value;
            out_status_reg <= step_result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg, out_value_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/btld_step.sv -----
// One decode step of the balanced base-27 length decoder.
// Combinational: current state and one tryte in, next state and result out.
// Depends on btld_pkg.
`default_nettype none

module btld_step #(
    parameter int MAX_DIGITS = 13,
    parameter int VALUE_BITS = 64
) (
    input  wire btld_pkg::btld_state_t                 state,
    input  wire logic signed [btld_pkg::TRYTE_W-1:0]   tryte,
    input  wire logic                                  ended,
    output btld_pkg::btld_state_t                      state_next,
    output btld_pkg::btld_result_t                     result
);

    logic signed [btld_pkg::TRYTE_W-1:0]    tryte_sat;
    logic signed [btld_pkg::WEIGHT_W:0]     weight_s;
    logic signed [btld_pkg::SUM_W-1:0]      product;
    logic signed [btld_pkg::SUM_W-1:0]      sum_new;
    logic        [btld_pkg::SUM_W-1:0]      sum_new_u;
    logic        [btld_pkg::WEIGHT_W-1:0]   weight_x27;
    logic                                   too_large;

    // Digits are clamped to the balanced range before use.
    always_comb begin
        if (tryte > btld_pkg::TRYTE_MAX) begin
            tryte_sat = btld_pkg::TRYTE_MAX;
        end else if (tryte < btld_pkg::TRYTE_MIN) begin
            tryte_sat = btld_pkg::TRYTE_MIN;
        end else begin
            tryte_sat = tryte;
        end
    end

    // Digit times weight, accumulated; the weight is multiplied by 27 with shifts.
    assign weight_s   = $signed({1'b0, state.digit_weight});
    assign product    = tryte_sat * weight_s;
    assign sum_new    = $signed(state.partial_sum) + product;
    assign sum_new_u  = sum_new;
    assign weight_x27 = (state.digit_weight << 4) + (state.digit_weight << 3)
                      + (state.digit_weight << 1) + state.digit_weight;

    // A finished value is positive, so any bit at or above VALUE_BITS is overflow.
    assign too_large = |(sum_new_u >> VALUE_BITS);

    // Step control.
    always_comb begin
        state_next    = state;
        result.emit   = 1'b0;
        result.value  = '0;
        result.status = btld_pkg::ST_OK;
        if (ended) begin
            state_next    = btld_pkg::STATE_IDLE;
            result.emit   = 1'b1;
            result.status = btld_pkg::ST_EOD;
        end else if (state.awaiting_count) begin
            if (tryte < 0 || tryte > MAX_DIGITS) begin
                result.emit   = 1'b1;
                result.status = btld_pkg::ST_BAD_COUNT;
            end else if (tryte == 0) begin
                result.emit   = 1'b1;
            end else begin
                state_next.awaiting_count = 1'b0;
                state_next.digits_left    = tryte[btld_pkg::COUNT_W-1:0];
                state_next.partial_sum    = '0;
                state_next.digit_weight   = btld_pkg::WEIGHT_W'(1);
            end
        end else if (state.digits_left > btld_pkg::COUNT_W'(1)) begin
            state_next.partial_sum  = sum_new_u;
            state_next.digit_weight = weight_x27;
            state_next.digits_left  = state.digits_left - btld_pkg::COUNT_W'(1);
        end else begin
            // Most significant digit closes the value.
            state_next  = btld_pkg::STATE_IDLE;
            result.emit = 1'b1;
            if (tryte_sat <= 0) begin
                result.status = btld_pkg::ST_BAD_TOP;
            end else if (too_large) begin
                result.status = btld_pkg::ST_TOO_LARGE;
            end else begin
                result.value = sum_new_u[btld_pkg::VALUE_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/btld_checker.sv -----
// Port-level checks for the balanced base-27 length decoder.
// Bound to balanced_tryte_length_decoder; uses btld_pkg status codes.
`default_nettype none

module btld_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [btld_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result beat keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only defined status codes leave the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[63:61] == btld_pkg::ST_OK
                   || m_tdata[63:61] == btld_pkg::ST_EOD
                   || m_tdata[63:61] == btld_pkg::ST_BAD_COUNT
                   || m_tdata[63:61] == btld_pkg::ST_BAD_TOP
                   || m_tdata[63:61] == btld_pkg::ST_TOO_LARGE))
        else $error("undefined status code");

    // Error and end-of-data results carry a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[63:61] != btld_pkg::ST_OK |-> m_tdata[60:0] == '0)
        else $error("error result with nonzero value");

    // With no result waiting, the input side is open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

endmodule

bind balanced_tryte_length_decoder btld_checker u_btld_checker (.*);

`default_nettype wire
